// File: hdl/top_k_index_select_defines.svh
// Assertion macros for the top-k index selector.
`ifndef TOP_K_INDEX_SELECT_DEFINES_SVH
`define TOP_K_INDEX_SELECT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TKIS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("top_k_index_select: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TKIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("top_k_index_select: next-cycle check failed");

`endif

// File: hdl/tkis_pkg.sv
// Shared constants, types and state encoding for the top-k index selector.
package tkis_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int MAX_RESULTS = 64;
    localparam int ADDR_BITS   = $clog2(MAX_ITEMS);
    localparam int CNT_BITS    = $clog2(MAX_ITEMS + 1);
    localparam int K_BITS      = $clog2(MAX_RESULTS + 1);
    localparam int POS_BITS    = 10;
    localparam int PICK_BITS   = 7;
    localparam int CFG_BITS    = 7;

    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_PICK_COUNT = 1'b1;

    typedef struct packed {
        logic                          chosen;
        logic signed [VALUE_BITS-1:0]  value;
    } t_entry;

    typedef struct packed {
        logic                  en;
        logic [ADDR_BITS-1:0]  addr;
        t_entry                data;
    } t_mem_wr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

// File: hdl/tkis_store.sv
// Value store: one entry per load position, holding the value and its chosen flag.
module tkis_store (
    input  logic                          i_clk,
    input  tkis_pkg::t_mem_wr             i_wr,
    input  logic                          i_rd_en,
    input  logic [tkis_pkg::ADDR_BITS-1:0] i_rd_addr,
    output tkis_pkg::t_entry              o_rd_data
);
    import tkis_pkg::*;

    t_entry r_mem [MAX_ITEMS];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/top_k_index_select.sv
// Top-k index selector: loads a signed set and emits the positions of its K extreme values.
//
// Items are taken one per cycle while the block is idle; each of the first 1024 is
// written to the value store at its load position. The item flagged last closes the set
// and the block then makes K picks, K being the pick count clamped to the set size and
// to 64. Each pick streams all N stored entries through the single read port of the
// store, one per cycle. The input is stalled during the picks. Each load write also
// clears that entry's chosen flag, so no clearing pass is needed after reset or between
// sets. Results wait in an output register, so the next pick scans while the previous
// position is still held.
`include "top_k_index_select_defines.svh"

module top_k_index_select (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_index,
    input  logic [tkis_pkg::CFG_BITS-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [tkis_pkg::VALUE_BITS-1:0] i_value,
    input  logic                              i_last_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tkis_pkg::POS_BITS-1:0]     o_position,
    output logic                              o_last_pick
);
    import tkis_pkg::*;

    t_state                       r_state, n_state;
    logic                         r_descending;
    logic [PICK_BITS-1:0]         r_pick_count;
    logic [CNT_BITS-1:0]          r_count, n_count;
    logic [ADDR_BITS-1:0]         r_last_addr;
    logic [K_BITS-1:0]            r_k, n_k;
    logic [K_BITS-1:0]            r_pick_idx;
    logic [ADDR_BITS-1:0]         r_addr;
    logic                         r_rd_valid;
    logic [ADDR_BITS-1:0]         r_rd_idx;
    logic                         r_have;
    logic [ADDR_BITS-1:0]         r_best_idx;
    logic signed [VALUE_BITS-1:0] r_best_val;
    logic                         r_out_valid;
    logic [POS_BITS-1:0]          r_position;
    logic                         r_last_pick;

    t_mem_wr                      mem_wr;
    logic                         rd_en;
    t_entry                       rd_data;
    logic                         in_acc;
    logic                         store_ok;
    logic                         set_end;
    logic                         out_free;
    logic                         emit;
    logic                         final_pick;
    logic                         better;
    logic [PICK_BITS-1:0]         k_cap;

    tkis_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign store_ok   = (r_count < CNT_BITS'(MAX_ITEMS));
    assign set_end    = in_acc && i_last_value;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign emit       = (r_state == ST_DONE) && out_free;
    assign final_pick = ((r_pick_idx + K_BITS'(1)) == r_k);

    always_comb begin
        n_count = r_count + (store_ok ? CNT_BITS'(1) : CNT_BITS'(0));
        k_cap   = (r_pick_count > PICK_BITS'(MAX_RESULTS)) ? PICK_BITS'(MAX_RESULTS)
                                                          : r_pick_count;
        if (CNT_BITS'(k_cap) > n_count) begin
            n_k = K_BITS'(n_count);
        end else begin
            n_k = K_BITS'(k_cap);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (set_end && (n_k != '0)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == r_last_addr) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = final_pick ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != ST_IDLE);
        rd_en            = (r_state == ST_SCAN);
        mem_wr           = '0;
        if (in_acc && store_ok) begin
            mem_wr.en          = 1'b1;
            mem_wr.addr        = r_count[ADDR_BITS-1:0];
            mem_wr.data.chosen = 1'b0;
            mem_wr.data.value  = i_value;
        end else if (emit) begin
            mem_wr.en          = 1'b1;
            mem_wr.addr        = r_best_idx;
            mem_wr.data.chosen = 1'b1;
            mem_wr.data.value  = r_best_val;
        end
    end

    always_comb begin
        if (r_descending) begin
            better = (rd_data.value > r_best_val);
        end else begin
            better = (rd_data.value < r_best_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_descending <= 1'b0;
            r_pick_count <= PICK_BITS'(1);
            r_count      <= '0;
            r_k          <= '0;
            r_pick_idx   <= '0;
            r_addr       <= '0;
            r_rd_valid   <= 1'b0;
            r_have       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DESCENDING: r_descending <= i_cfg_data[0];
                    REG_PICK_COUNT: r_pick_count <= i_cfg_data[PICK_BITS-1:0];
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_count <= set_end ? '0 : n_count;
            end
            if (set_end) begin
                r_k        <= n_k;
                r_pick_idx <= '0;
                r_addr     <= '0;
                r_have     <= 1'b0;
            end

            if (rd_en) begin
                r_addr <= r_addr + ADDR_BITS'(1);
            end

            if (r_rd_valid && !rd_data.chosen && (!r_have || better)) begin
                r_have <= 1'b1;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_pick_idx  <= r_pick_idx + K_BITS'(1);
                r_addr      <= '0;
                r_have      <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_end) begin
            r_last_addr <= ADDR_BITS'(n_count - CNT_BITS'(1));
        end
        r_rd_idx <= r_addr;
        if (r_rd_valid && !rd_data.chosen && (!r_have || better)) begin
            r_best_idx <= r_rd_idx;
            r_best_val <= rd_data.value;
        end
        if (emit) begin
            r_position  <= POS_BITS'(r_best_idx);
            r_last_pick <= final_pick;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;
    assign o_last_pick = r_last_pick;

    `TKIS_ASSERT_NOW(a_done_has_best, (r_state == ST_DONE), r_have)
    `TKIS_ASSERT_NOW(a_pick_in_range, (r_state != ST_IDLE), (r_pick_idx < r_k))
    `TKIS_ASSERT_NEXT(a_emit_sets_valid, emit, (o_out_valid && (o_last_pick == $past(final_pick))))

endmodule

// File: sim/tb_top_k_index_select.sv
// Self-checking testbench for the top-k index selector with a built-in ranking predictor.
`timescale 1ns / 100ps

module tb_top_k_index_select;
    import tkis_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = MAX_ITEMS + 100;
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic signed [VALUE_BITS-1:0] value;
        logic                         last;
    } t_element;

    typedef struct {
        logic [POS_BITS-1:0] position;
        logic                last_pick;
    } t_pick;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic                          i_cfg_index  = 1'b0;
    logic [CFG_BITS-1:0]           i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_stall;
    logic signed [VALUE_BITS-1:0]  i_value      = '0;
    logic                          i_last_value = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall  = 1'b0;
    logic [POS_BITS-1:0]           o_position;
    logic                          o_last_pick;

    t_element queued_elements[$];
    t_pick    expected_picks[$];

    logic signed [VALUE_BITS-1:0] stored_values [MAX_ITEMS];
    bit                           taken [MAX_ITEMS];
    int                           stored_count = 0;
    bit                           sort_desc    = 1'b0;
    int                           pick_limit   = 1;

    int fail_count  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int idle_left   = 0;
    int stall_mode  = 0;
    int stall_cycle = 0;

    logic signed [VALUE_BITS-1:0] mixed_set [7] = '{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MIN, VAL_MAX};

    top_k_index_select u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_last_value (i_last_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_position   (o_position),
        .o_last_pick  (o_last_pick)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stores one element and, when it closes the set, queues the positions of its K extremes.
    task automatic store_and_rank(input logic signed [VALUE_BITS-1:0] v, input logic last);
        int    n;
        int    k;
        int    best;
        bit    have;
        t_pick p;
        if (stored_count < MAX_ITEMS) begin
            stored_values[stored_count] = v;
            stored_count++;
        end
        if (last) begin
            n = stored_count;
            stored_count = 0;
            for (int i = 0; i < n; i++) taken[i] = 1'b0;
            k = pick_limit;
            if (k > n) k = n;
            if (k > MAX_RESULTS) k = MAX_RESULTS;
            for (int i = 0; i < k; i++) begin
                have = 1'b0;
                best = 0;
                for (int j = 0; j < n; j++) begin
                    if (!taken[j] && (!have || (sort_desc ? stored_values[j] > stored_values[best]
                                                         : stored_values[j] < stored_values[best]))) begin
                        have = 1'b1;
                        best = j;
                    end
                end
                taken[best] = 1'b1;
                p.position  = best[POS_BITS-1:0];
                p.last_pick = (i + 1 == k);
                expected_picks.push_back(p);
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_DESCENDING) sort_desc = data[0];
        else pick_limit = int'(data);
    endtask

    task automatic add_element(input logic signed [VALUE_BITS-1:0] v, input logic last);
        t_element e;
        e.value = v;
        e.last  = last;
        queued_elements.push_back(e);
    endtask

    task automatic wait_for_idle();
        while (queued_elements.size() != 0 || i_in_valid || expected_picks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_element nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) store_and_rank(i_value, i_last_value);
            if (!i_in_valid || !o_in_stall) begin
                if (idle_left > 0) begin
                    idle_left--;
                    i_in_valid <= 1'b0;
                end else if (queued_elements.size() > 0) begin
                    nxt = queued_elements.pop_front();
                    i_in_valid   <= 1'b1;
                    i_value      <= nxt.value;
                    i_last_value <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        case ($urandom_range(0, 3))
                            0, 1: idle_left = 0;
                            2: idle_left = $urandom_range(1, 3);
                            default: idle_left = $urandom_range(4, 20);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_pick exp_pick;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_picks.size() == 0) begin
                $error("position: expected none, actual %0d", o_position);
                fail_count++;
            end else begin
                exp_pick = expected_picks.pop_front();
                if (o_position !== exp_pick.position) begin
                    $error("position: expected %0d, actual %0d", exp_pick.position, o_position);
                    fail_count++;
                end
                if (o_last_pick !== exp_pick.last_pick) begin
                    $error("last_pick: expected %0b, actual %0b", exp_pick.last_pick, o_last_pick);
                    fail_count++;
                end
            end
        end
        if (stall_cycle == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_cycle = 300;
        end else begin
            stall_cycle--;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ((cycle_count % 7) < 3);
            default: i_out_stall <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("top_k_index_select test failed");
            $finish;
        end
    end

    initial begin
        int                           n;
        int                           count;
        logic signed [VALUE_BITS-1:0] v;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sets: extremes, ties, both orders and a zero count.
        write_reg(REG_DESCENDING, CFG_BITS'(0));
        write_reg(REG_PICK_COUNT, CFG_BITS'(64));
        add_element(VAL_MIN, 1'b1);
        for (int i = 0; i < 7; i++) add_element(mixed_set[i], i == 6);
        for (int i = 0; i < 4; i++) add_element(5, i == 3);
        wait_for_idle();
        write_reg(REG_DESCENDING, CFG_BITS'(1));
        for (int i = 0; i < 7; i++) add_element(mixed_set[i], i == 6);
        add_element(VAL_MAX, 1'b1);
        wait_for_idle();
        write_reg(REG_PICK_COUNT, CFG_BITS'(0));
        for (int i = 0; i < 3; i++) add_element(i, i == 2);
        wait_for_idle();

        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_DESCENDING, CFG_BITS'(phase < 4 ? phase % 2 : $urandom_range(0, 1)));
            case (phase)
                0: write_reg(REG_PICK_COUNT, CFG_BITS'(0));
                1: write_reg(REG_PICK_COUNT, CFG_BITS'(64));
                2: write_reg(REG_PICK_COUNT, CFG_BITS'(1));
                3: write_reg(REG_PICK_COUNT, CFG_BITS'($urandom_range(2, 8)));
                default: write_reg(REG_PICK_COUNT, CFG_BITS'($urandom_range(0, 64)));
            endcase
            count = 0;
            while (count < 28) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        1: v = int'($urandom_range(0, 8)) - 4;
                        2: begin
                            case ($urandom_range(0, 3))
                                0: v = VAL_MIN;
                                1: v = VAL_MAX;
                                2: v = 0;
                                default: v = -1;
                            endcase
                        end
                        default: v = $urandom;
                    endcase
                    add_element(v, i == n - 1);
                end
                count += n;
            end
            wait_for_idle();
        end

        if (expected_picks.size() != 0) begin
            $error("position: expected %0d more, actual none", expected_picks.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("top_k_index_select test passed");
        end else begin
            $display("top_k_index_select test failed");
        end
        $finish;
    end

endmodule
